// ===== hdl/sbs_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the spectrum bin statistics block
// no dependencies; imported by every module of the block
package sbs_pkg;

   localparam logic [15:0]       REPORT_SWEEPS_RESET = 16'd151;
   localparam logic signed [7:0] PEAK_RESET          = -8'sd128;
   localparam logic [6:0]        SPREAD_MAX          = 7'd127;
   localparam logic [31:0]       ROOT_FIRST_BIT      = 32'h4000_0000;
   localparam logic [7:0]        RECIP3              = 8'd171;
   localparam int                RECIP3_SHIFT        = 9;
   localparam int                DIV_STEPS           = 32;
   localparam int                ROOT_STEPS          = 16;
   localparam int                STEP_CNT_W          = 5;

   // operations of the shared compare-subtract unit
   typedef enum logic [2:0] {
      OP_NOP,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_ROOT_LOAD,
      OP_ROOT_STEP
   } sbs_step_op_type;

   typedef struct packed {
      sbs_step_op_type op;
      logic [31:0]     operand_a;
      logic [31:0]     operand_b;
   } sbs_step_cmd_type;

   typedef struct packed {
      logic signed [7:0]  peak;
      logic signed [31:0] sum;
      logic [31:0]        square_sum;
   } sbs_entry_type;

   localparam sbs_entry_type ENTRY_RESET = '{peak: PEAK_RESET, sum: '0, square_sum: '0};

   // truncating divide by three of a three-sample sum, reciprocal multiply
   function automatic logic signed [7:0] div3(input logic signed [9:0] s);
      logic [9:0]  mag;
      logic [16:0] prod;
      logic [7:0]  q;
      mag  = s[9] ? 10'(-s) : 10'(s);
      prod = 17'(mag) * 17'(RECIP3);
      q    = prod[RECIP3_SHIFT +: 8];
      return s[9] ? 8'(-q) : 8'(q);
   endfunction

   function automatic logic signed [7:0] max3(input logic signed [7:0] a,
                                              input logic signed [7:0] b,
                                              input logic signed [7:0] c);
      logic signed [7:0] m;
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
   endfunction

endpackage

// ===== hdl/sbs_bin_store.sv =====
`timescale 1ns / 1ps
// per-bin accumulator memory: peak, sum of averages, sum of squares
// registered read, one write port, valid bits give the reset contents; uses sbs_pkg
module sbs_bin_store
   import sbs_pkg::*;
#(
   parameter int BINS   = 80,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output sbs_entry_type     rd_entry,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  sbs_entry_type     wr_entry
);

   sbs_entry_type mem_ff [BINS];
   logic [BINS-1:0] valid_ff;
   sbs_entry_type rd_data_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // an entry never written reads as the cleared value
   assign rd_entry = rd_valid_ff ? rd_data_ff : ENTRY_RESET;

endmodule

// ===== hdl/sbs_step_unit.sv =====
`timescale 1ns / 1ps
// shared compare-subtract unit: restoring divide and bit-by-bit square root
// one step per cycle under the sequencer in the top level; uses sbs_pkg
module sbs_step_unit
   import sbs_pkg::*;
(
   input  logic             clock,
   input  sbs_step_cmd_type cmd,
   output logic [31:0]      result
);

   logic [32:0] acc_ff, acc_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] opnd_ff, opnd_in;
   logic [33:0] minuend, subtrahend, diff;
   logic        fits;

   always_comb begin
      case (cmd.op)
         OP_DIV_STEP: begin
            minuend    = {1'b0, acc_ff[31:0], quo_ff[31]};
            subtrahend = {2'b00, opnd_ff};
         end
         OP_ROOT_STEP: begin
            minuend    = {1'b0, acc_ff};
            subtrahend = 34'(quo_ff) + 34'(opnd_ff);
         end
         default: begin
            minuend    = '0;
            subtrahend = '0;
         end
      endcase
      diff = minuend - subtrahend;
      fits = ~diff[33];
   end

   always_comb begin
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      opnd_in = opnd_ff;
      case (cmd.op)
         OP_DIV_LOAD: begin
            acc_in  = '0;
            quo_in  = cmd.operand_a;
            opnd_in = cmd.operand_b;
         end
         OP_DIV_STEP: begin
            acc_in = fits ? diff[32:0] : minuend[32:0];
            quo_in = {quo_ff[30:0], fits};
         end
         OP_ROOT_LOAD: begin
            acc_in  = {1'b0, cmd.operand_a};
            quo_in  = '0;
            opnd_in = ROOT_FIRST_BIT;
         end
         OP_ROOT_STEP: begin
            acc_in  = fits ? diff[32:0] : acc_ff;
            quo_in  = fits ? (quo_ff >> 1) + opnd_ff : quo_ff >> 1;
            opnd_in = opnd_ff >> 2;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      quo_ff  <= quo_in;
      opnd_ff <= opnd_in;
   end

   // quotient or root
   assign result = quo_ff;

endmodule

// ===== hdl/spectrum_bin_statistics_core.sv =====
`timescale 1ns / 1ps
// spectrum bin statistics: per-bin peak, mean and spread over a window of sweeps
// a word that does not report goes through accept, then read-modify-write of its bin
// a reporting word then runs two 32-step divides and a 16-step root on the one shared
// compare-subtract unit; its result waits in the done state until the output register is free
// synchronous active-high reset; bin store contents come from per-bin valid bits, no
// clearing pass; report_sweeps resets to 151; uses sbs_pkg, sbs_bin_store, sbs_step_unit
module spectrum_bin_statistics_core
   import sbs_pkg::*;
#(
   parameter int BINS = 80
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic signed [7:0] req_sample_a,
   input  logic signed [7:0] req_sample_b,
   input  logic signed [7:0] req_sample_c,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_bin_index,
   output logic signed [7:0] rsp_peak_level,
   output logic signed [7:0] rsp_mean_level,
   output logic [6:0]        rsp_spread_level,
   output logic              rsp_last_bin,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_report_sweeps
);

   localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(BINS - 1);
   localparam logic [STEP_CNT_W-1:0] DIV_LAST  = STEP_CNT_W'(DIV_STEPS - 1);
   localparam logic [STEP_CNT_W-1:0] ROOT_LAST = STEP_CNT_W'(ROOT_STEPS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_MEAN_LOAD,
      S_MEAN_DIV,
      S_EX2_LOAD,
      S_EX2_DIV,
      S_SQUARE,
      S_VAR,
      S_ROOT,
      S_DONE
   } state_type;

   state_type state_ff;

   // window control
   logic [15:0]       report_sweeps_ff;
   logic [ADDR_W-1:0] bin_pos_ff;
   logic [15:0]       sweep_count_ff;
   logic [STEP_CNT_W-1:0] step_cnt_ff;

   // per-word working registers
   logic [ADDR_W-1:0]  pos_ff;
   logic               report_ff;
   logic               last_ff;
   logic [16:0]        count_ff;
   logic [17:0]        count3_ff;
   logic signed [7:0]  top_ff;
   logic signed [7:0]  avg_ff;
   logic [15:0]        sq_total_ff;
   logic signed [7:0]  peak_ff;
   logic signed [31:0] sum_ff;
   logic [31:0]        square_sum_ff;
   logic [31:0]        mean_ff;
   logic [31:0]        ex2_ff;
   logic [31:0]        msq_ff;

   // result word
   logic              rsp_valid_ff;
   logic [6:0]        rsp_bin_index_ff;
   logic signed [7:0] rsp_peak_level_ff;
   logic signed [7:0] rsp_mean_level_ff;
   logic [6:0]        rsp_spread_level_ff;
   logic              rsp_last_bin_ff;

   logic              req_accept;
   logic              last_now;
   logic [16:0]       count_now;
   logic              report_now;
   logic signed [9:0] sample_sum;
   logic signed [15:0] sq_a, sq_b, sq_c;
   logic [15:0]       sq_total;

   sbs_entry_type    rd_entry, new_entry, wr_entry;
   sbs_step_cmd_type step_cmd;
   logic [31:0]      step_result;
   logic [31:0]      sum_mag;
   logic [31:0]      variance;
   logic             rsp_free;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid & req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = ~rsp_valid_ff | rsp_ready;

   // position and window count as seen by the word being accepted
   assign last_now   = (bin_pos_ff == LAST_POS);
   assign count_now  = 17'(sweep_count_ff) + 17'd1;
   assign report_now = (count_now >= 17'(report_sweeps_ff));

   // per-word sample terms
   assign sample_sum = 10'(req_sample_a) + 10'(req_sample_b) + 10'(req_sample_c);
   assign sq_a       = 16'(req_sample_a) * 16'(req_sample_a);
   assign sq_b       = 16'(req_sample_b) * 16'(req_sample_b);
   assign sq_c       = 16'(req_sample_c) * 16'(req_sample_c);
   assign sq_total   = $unsigned(sq_a) + $unsigned(sq_b) + $unsigned(sq_c);

   // accumulate into the entry just read
   always_comb begin
      new_entry.peak       = (rd_entry.peak < top_ff) ? top_ff : rd_entry.peak;
      new_entry.sum        = rd_entry.sum + 32'(avg_ff);
      new_entry.square_sum = rd_entry.square_sum + 32'(sq_total_ff);
      // a reporting bin starts its next window cleared
      wr_entry             = report_ff ? ENTRY_RESET : new_entry;
   end

   assign sum_mag  = sum_ff[31] ? 32'(-sum_ff) : 32'(sum_ff);
   assign variance = (ex2_ff > msq_ff) ? ex2_ff - msq_ff : '0;

   // command to the shared unit for each sequencer step
   always_comb begin
      step_cmd = '{op: OP_NOP, operand_a: '0, operand_b: '0};
      case (state_ff)
         S_MEAN_LOAD: step_cmd = '{op: OP_DIV_LOAD, operand_a: sum_mag,
                                   operand_b: 32'(count_ff)};
         S_MEAN_DIV:  step_cmd.op = OP_DIV_STEP;
         S_EX2_LOAD:  step_cmd = '{op: OP_DIV_LOAD, operand_a: square_sum_ff,
                                   operand_b: 32'(count3_ff)};
         S_EX2_DIV:   step_cmd.op = OP_DIV_STEP;
         S_VAR:       step_cmd = '{op: OP_ROOT_LOAD, operand_a: variance, operand_b: '0};
         S_ROOT:      step_cmd.op = OP_ROOT_STEP;
         default:     step_cmd.op = OP_NOP;
      endcase
   end

   sbs_bin_store #(
      .BINS   (BINS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (bin_pos_ff),
      .rd_entry (rd_entry),
      .wr_en    (state_ff == S_FETCH),
      .wr_addr  (pos_ff),
      .wr_entry (wr_entry)
   );

   sbs_step_unit u_step (
      .clock  (clock),
      .cmd    (step_cmd),
      .result (step_result)
   );

   // sequencer, window control and result word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         report_sweeps_ff <= REPORT_SWEEPS_RESET;
         bin_pos_ff       <= '0;
         sweep_count_ff   <= '0;
         step_cnt_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            report_sweeps_ff <= csr_report_sweeps;
         end
         // a new result loaded in the done step takes over the valid flag
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  pos_ff      <= bin_pos_ff;
                  report_ff   <= report_now;
                  last_ff     <= last_now;
                  count_ff    <= count_now;
                  count3_ff   <= {count_now, 1'b0} + 18'(count_now);
                  top_ff      <= max3(req_sample_a, req_sample_b, req_sample_c);
                  avg_ff      <= div3(sample_sum);
                  sq_total_ff <= sq_total;
                  // advance to the next bin; the window restarts after a report sweep
                  if (last_now) begin
                     bin_pos_ff <= '0;
                     if (report_now) begin
                        sweep_count_ff <= '0;
                     end else if (count_now[16]) begin
                        sweep_count_ff <= '1;
                     end else begin
                        sweep_count_ff <= count_now[15:0];
                     end
                  end else begin
                     bin_pos_ff <= bin_pos_ff + ADDR_W'(1);
                  end
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               peak_ff       <= new_entry.peak;
               sum_ff        <= new_entry.sum;
               square_sum_ff <= new_entry.square_sum;
               state_ff      <= report_ff ? S_MEAN_LOAD : S_IDLE;
            end
            S_MEAN_LOAD: begin
               step_cnt_ff <= '0;
               state_ff    <= S_MEAN_DIV;
            end
            S_MEAN_DIV: begin
               step_cnt_ff <= step_cnt_ff + STEP_CNT_W'(1);
               if (step_cnt_ff == DIV_LAST) begin
                  state_ff <= S_EX2_LOAD;
               end
            end
            S_EX2_LOAD: begin
               // mean truncates toward zero: sign of the sum on the magnitude quotient
               mean_ff     <= sum_ff[31] ? 32'(-step_result) : step_result;
               step_cnt_ff <= '0;
               state_ff    <= S_EX2_DIV;
            end
            S_EX2_DIV: begin
               step_cnt_ff <= step_cnt_ff + STEP_CNT_W'(1);
               if (step_cnt_ff == DIV_LAST) begin
                  state_ff <= S_SQUARE;
               end
            end
            S_SQUARE: begin
               ex2_ff   <= step_result;
               msq_ff   <= 32'(mean_ff * mean_ff);
               state_ff <= S_VAR;
            end
            S_VAR: begin
               step_cnt_ff <= '0;
               state_ff    <= S_ROOT;
            end
            S_ROOT: begin
               step_cnt_ff <= step_cnt_ff + STEP_CNT_W'(1);
               if (step_cnt_ff == ROOT_LAST) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // wait for the output register to free up
               if (rsp_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_bin_index_ff    <= 7'(pos_ff);
                  rsp_peak_level_ff   <= peak_ff;
                  rsp_mean_level_ff   <= mean_ff[7:0];
                  rsp_spread_level_ff <= (step_result > 32'(SPREAD_MAX)) ?
                                         SPREAD_MAX : step_result[6:0];
                  rsp_last_bin_ff     <= last_ff;
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bin_index    = rsp_bin_index_ff;
   assign rsp_peak_level   = rsp_peak_level_ff;
   assign rsp_mean_level   = rsp_mean_level_ff;
   assign rsp_spread_level = rsp_spread_level_ff;
   assign rsp_last_bin     = rsp_last_bin_ff;

endmodule
